FILE: design/canonical_kmer_counter_defines.svh
// Assertion macros shared by the checker.
`ifndef CANONICAL_KMER_COUNTER_DEFINES_SVH
`define CANONICAL_KMER_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while dis is high.
`define CKC_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("canonical_kmer_counter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while dis is high.
`define CKC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("canonical_kmer_counter: next-cycle check failed");

`endif

FILE: design/ckc_pkg.sv
`default_nettype none

package ckc_pkg;

    localparam int KMER_LEN_DEF = 12;
    localparam int TABLE_BITS   = 24;
    localparam int COUNT_W      = 7;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd127;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] base_char;
        logic       read_start;
    } ckc_in_t;

    typedef struct packed {
        logic                  kmer_ready;
        logic [TABLE_BITS-1:0] canonical_index;
        logic [COUNT_W-1:0]    kmer_count;
    } ckc_out_t;

    typedef struct packed {
        logic ok;
        logic [1:0] code;
    } ckc_base_t;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic take_item;
        logic mem_read;
        logic commit;
    } ckc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;
    } ckc_stat_t;

    function automatic ckc_base_t ckc_decode(input logic [7:0] c);
        ckc_base_t r;
        r.ok   = 1'b1;
        r.code = 2'd0;
        unique case (c)
            8'h41, 8'h61: r.code = 2'd0;
            8'h54, 8'h74: r.code = 2'd1;
            8'h43, 8'h63: r.code = 2'd2;
            8'h47, 8'h67: r.code = 2'd3;
            default:      r.ok   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ckc_ctrl.sv
`default_nettype none

module ckc_ctrl
    import ckc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire ckc_stat_t stat,
    output ckc_cmd_t       cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output slot frees up
                if (!out_valid_reg || m_ready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/ckc_datapath.sv
`default_nettype none

module ckc_datapath
    import ckc_pkg::*;
#(
    parameter int KMER_LEN = KMER_LEN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ckc_cmd_t           cmd,
    output ckc_stat_t               stat,
    input  wire ckc_in_t            s_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    output ckc_out_t                m_data
);

    localparam int IDX_W = 2 * KMER_LEN;
    localparam int RUN_W = $clog2(KMER_LEN + 1);
    localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(KMER_LEN);

    logic [IDX_W-1:0]      fwd_reg, fwd_next, rev_reg, rev_next;
    logic [IDX_W-1:0]      fwd_base, rev_base, canon;
    logic [RUN_W-1:0]      run_reg, run_next, run_base;
    logic [1:0]            code;
    ckc_base_t             dec;
    logic                  win_reg, op_reg;
    logic [COUNT_W-1:0]    limit_reg;
    logic [TABLE_BITS-1:0] clr_addr_reg, addr_reg;
    logic [COUNT_W-1:0]    rd_data_reg;
    logic [COUNT_W-1:0]    mem [2**TABLE_BITS];
    logic                  mem_we, bump;
    logic [TABLE_BITS-1:0] mem_waddr;
    logic [COUNT_W-1:0]    mem_wdata, cnt_res;
    ckc_out_t              out_reg, out_next;

    // Window update for the item being taken.
    always_comb begin
        dec      = ckc_decode(s_data.base_char);
        code     = dec.ok ? dec.code : 2'd0;
        fwd_base = s_data.read_start ? '0 : fwd_reg;
        rev_base = s_data.read_start ? '0 : rev_reg;
        run_base = s_data.read_start ? '0 : run_reg;
        fwd_next = {fwd_base[IDX_W-3:0], code};
        rev_next = {code ^ 2'b01, rev_base[IDX_W-1:2]};
        if (!dec.ok) begin
            run_next = '0;
        end else if (run_base < RUN_FULL) begin
            run_next = run_base + 1'b1;
        end else begin
            run_next = run_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg      <= '0;
            rev_reg      <= '0;
            run_reg      <= '0;
            win_reg      <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.take_item) begin
                fwd_reg <= fwd_next;
                rev_reg <= rev_next;
                run_reg <= run_next;
                win_reg <= (run_next == RUN_FULL);
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg <= s_data.opcode;
        end
    end

    assign stat.clr_last = &clr_addr_reg;
    assign canon = (fwd_reg < rev_reg) ? fwd_reg : rev_reg;

    // Result of the table access.
    always_comb begin
        bump    = win_reg && (op_reg == OP_COUNT) && (rd_data_reg < limit_reg);
        cnt_res = '0;
        if (win_reg) begin
            if (op_reg == OP_COUNT) begin
                cnt_res = bump ? rd_data_reg + 1'b1 : rd_data_reg;
            end else if (addr_reg != '0) begin
                cnt_res = rd_data_reg;
            end
        end
        out_next.kmer_ready      = win_reg;
        out_next.canonical_index = win_reg ? addr_reg : '0;
        out_next.kmer_count      = cnt_res;
    end

    always_comb begin
        mem_we    = cmd.clr_step || (cmd.commit && bump);
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_reg;
        mem_wdata = cmd.clr_step ? '0 : cnt_res;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read) begin
            rd_data_reg <= mem[TABLE_BITS'(canon)];
            addr_reg    <= TABLE_BITS'(canon);
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

FILE: design/canonical_kmer_counter.sv
// Canonical k-mer counter.
// Input channel s_valid/s_ready/s_data carries one ASCII base per transfer,
// with an opcode (count or lookup) and a read-start flag. Result channel
// m_valid/m_ready/m_data returns exactly one result per input transfer.
// cfg_wr_en/cfg_wr_data write the saturation limit; write it only while
// no item is in flight.
// Each item passes the window update, the table read, then the table
// write and result load together.
// The block takes no new item until the last one is committed, held back
// by the single-port read-modify-write of the count table.
// Reset: the window and the limit (127) reset at once, then a clearing
// pass writes zero to all 2^24 table entries, one per cycle; s_ready
// stays low until it ends.
// A stalled receiver holds the result in the output register; one more item
// can be taken and processed meanwhile, and it waits at the table write.
`default_nettype none

module canonical_kmer_counter
    import ckc_pkg::*;
#(
    parameter int KMER_LEN = KMER_LEN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ckc_in_t            s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ckc_out_t                m_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    ckc_cmd_t  cmd;
    ckc_stat_t stat;

    ckc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ckc_datapath #(
        .KMER_LEN (KMER_LEN)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

FILE: design/ckc_checker.sv
`default_nettype none
`include "canonical_kmer_counter_defines.svh"

module ckc_checker
    import ckc_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire ckc_out_t           m_data
);

    logic never;
    assign never = 1'b0;

    // reset empties the output and starts the clearing pass
    `CKC_ASSERT_NEXT(a_reset_quiet, aclk, never, !aresetn, !m_valid && !s_ready)
    // one item at a time
    `CKC_ASSERT_NEXT(a_one_in_flight, aclk, !aresetn, s_valid && s_ready, !s_ready)
    // a window that is not full reports nothing
    `CKC_ASSERT_NOW(a_empty_window, aclk, !aresetn, m_valid && !m_data.kmer_ready,
        m_data.canonical_index == '0 && m_data.kmer_count == '0)
    // a stalled result holds
    `CKC_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))

endmodule

bind canonical_kmer_counter ckc_checker u_ckc_checker (.*);

`default_nettype wire

FILE: sim/canonical_kmer_counter_tb.sv
`default_nettype none

module canonical_kmer_counter_tb;
    import ckc_pkg::*;

    localparam int KLEN       = KMER_LEN_DEF;
    localparam int IDX_W      = 2 * KLEN;
    localparam int NUM_MOTIFS = 6;
    localparam int MOTIF_MAX  = 6;
    localparam int SEG_ITEMS  = 275;

    // Tracks the rolling k-mer window and the count table, and holds the
    // results still owed by the block.
    class kmer_tally;
        bit [IDX_W-1:0]      fwd_idx;
        bit [IDX_W-1:0]      rc_idx;
        int                  run_len;
        bit [COUNT_W-1:0]    limit;
        bit [COUNT_W-1:0]    counts [bit [TABLE_BITS-1:0]];
        ckc_out_t            due_q[$];
        int unsigned         failures;
        int unsigned         checked;
        int unsigned         full_windows;
        int unsigned         held;

        function new();
            limit = LIMIT_RESET;
        endfunction

        static function int code_of(bit [7:0] c);
            case (c)
                "A", "a": return 0;
                "T", "t": return 1;
                "C", "c": return 2;
                "G", "g": return 3;
                default:  return -1;
            endcase
        endfunction

        function void set_limit(bit [COUNT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_base(ckc_in_t t);
            int                   code;
            bit [1:0]             sh;
            bit [IDX_W-1:0]       canon;
            bit [TABLE_BITS-1:0]  addr;
            bit [COUNT_W-1:0]     cnt;
            ckc_out_t             res;
            if (t.read_start) begin
                fwd_idx = '0;
                rc_idx  = '0;
                run_len = 0;
            end
            code = code_of(t.base_char);
            if (code < 0) begin
                sh = 2'd0;
                run_len = 0;
            end else begin
                sh = code[1:0];
                if (run_len < KLEN) run_len++;
            end
            fwd_idx = {fwd_idx[IDX_W-3:0], sh};
            rc_idx  = {sh ^ 2'b01, rc_idx[IDX_W-1:2]};
            res = '0;
            if (run_len >= KLEN) begin
                canon = (fwd_idx < rc_idx) ? fwd_idx : rc_idx;
                addr  = canon[TABLE_BITS-1:0];
                cnt   = counts.exists(addr) ? counts[addr] : '0;
                if (t.opcode == OP_COUNT) begin
                    if (cnt < limit) begin
                        cnt = cnt + 1'b1;
                        counts[addr] = cnt;
                    end else begin
                        held++;
                    end
                end else if (addr == '0) begin
                    cnt = '0;
                end
                res.kmer_ready      = 1'b1;
                res.canonical_index = addr;
                res.kmer_count      = cnt;
                full_windows++;
            end
            due_q = {due_q, res};
        endfunction

        function void check_result(ckc_out_t r);
            ckc_out_t e;
            checked++;
            if (due_q.size() == 0) begin
                $error("result with nothing outstanding: %p", r);
                failures++;
                return;
            end
            e = due_q.pop_front();
            if (r.kmer_ready !== e.kmer_ready) begin
                $error("kmer_ready: expected %0d, got %0d", e.kmer_ready, r.kmer_ready);
                failures++;
            end
            if (r.canonical_index !== e.canonical_index) begin
                $error("canonical_index: expected 0x%06h, got 0x%06h",
                       e.canonical_index, r.canonical_index);
                failures++;
            end
            if (r.kmer_count !== e.kmer_count) begin
                $error("kmer_count: expected %0d, got %0d", e.kmer_count, r.kmer_count);
                failures++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    ckc_in_t             s_data;
    logic                m_valid;
    logic                m_ready;
    ckc_out_t            m_data;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;

    kmer_tally   tally = new();
    int          send_idle_pct;
    int          recv_idle_pct;
    int          bases_sent;
    bit [1:0]    motif [NUM_MOTIFS][MOTIF_MAX];
    int          motif_len [NUM_MOTIFS];
    int          seg_limit [6];

    canonical_kmer_counter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tally.note_base(s_data);
            if (m_valid && m_ready) tally.check_result(m_data);
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic ckc_in_t base_item(logic op, logic [7:0] ch, logic rs);
        ckc_in_t t;
        t.opcode     = op;
        t.base_char  = ch;
        t.read_start = rs;
        return t;
    endfunction

    function automatic logic [7:0] letter(bit [1:0] code, bit lower);
        logic [7:0] ch;
        case (code)
            2'd0:    ch = "A";
            2'd1:    ch = "T";
            2'd2:    ch = "C";
            default: ch = "G";
        endcase
        return lower ? (ch | 8'h20) : ch;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(255)); while (kmer_tally::code_of(ch) >= 0);
        return ch;
    endfunction

    // Called and returns at a falling edge; valid drops after the transfer.
    task automatic send_item(ckc_in_t t);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            @(negedge aclk);
        s_valid = 1'b1;
        s_data  = t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        bases_sent++;
    endtask

    task automatic wait_drained();
        while (tally.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_limit(bit [COUNT_W-1:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        tally.set_limit(v);
    endtask

    // One read: mostly repeated motifs and homopolymers so k-mers recur,
    // some plain random reads, and some raw byte noise.
    task automatic send_read();
        int         kind;
        int         len;
        int         mot;
        int         pos;
        bit [1:0]   code;
        logic [7:0] ch;
        logic       op;
        logic       rs;
        kind = $urandom_range(99);
        if (kind < 10) begin
            len = $urandom_range(1, 8);
            for (pos = 0; pos < len; pos++)
                send_item(base_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                                    1'($urandom_range(1))));
        end else begin
            len  = (kind < 25) ? $urandom_range(13, 140) : $urandom_range(12, 60);
            mot  = $urandom_range(NUM_MOTIFS - 1);
            code = 2'($urandom_range(3));
            for (pos = 0; pos < len; pos++) begin
                if (kind >= 45) code = motif[mot][pos % motif_len[mot]];
                else if (kind >= 25) code = 2'($urandom_range(3));
                ch = letter(code, 1'($urandom_range(1)));
                if ($urandom_range(99) < 2) ch = junk_char();
                else if ($urandom_range(99) < 3) ch = letter(2'($urandom_range(3)), 1'b0);
                rs = (pos == 0) || ($urandom_range(199) == 0);
                op = ($urandom_range(99) < 30) ? OP_LOOKUP : OP_COUNT;
                send_item(base_item(op, ch, rs));
            end
        end
    endtask

    initial begin
        int seg;
        int target;
        int m;
        int k;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bases_sent    = 0;
        for (m = 0; m < NUM_MOTIFS; m++) begin
            motif_len[m] = $urandom_range(1, MOTIF_MAX);
            for (k = 0; k < MOTIF_MAX; k++) motif[m][k] = 2'($urandom_range(3));
        end
        seg_limit[0] = 127;
        seg_limit[1] = 5;
        seg_limit[2] = 1;
        seg_limit[3] = 0;
        seg_limit[4] = 127;
        seg_limit[5] = $urandom_range(2, 126);

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        // hold until the table clear finishes
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);

        // all-A window: index 0 for lookup and count, then invalid chars and restarts
        send_item(base_item(OP_LOOKUP, "A", 1'b1));
        repeat (11) send_item(base_item(OP_LOOKUP, "a", 1'b0));
        send_item(base_item(OP_COUNT, "A", 1'b0));
        send_item(base_item(OP_LOOKUP, "a", 1'b0));
        send_item(base_item(OP_COUNT, "T", 1'b0));
        send_item(base_item(OP_COUNT, "g", 1'b0));
        send_item(base_item(OP_COUNT, "C", 1'b1));
        send_item(base_item(OP_COUNT, 8'hFF, 1'b0));
        send_item(base_item(OP_LOOKUP, 8'h00, 1'b1));
        send_item(base_item(OP_COUNT, "t", 1'b0));
        send_item(base_item(OP_LOOKUP, "c", 1'b0));
        send_item(base_item(OP_COUNT, "G", 1'b0));

        for (seg = 0; seg < 6; seg++) begin
            wait_drained();
            write_limit(COUNT_W'(seg_limit[seg]));
            send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 80 : 0;
            recv_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 35 : 0;
            target = bases_sent + SEG_ITEMS;
            while (bases_sent < target) send_read();
        end

        wait_drained();
        repeat (16) @(negedge aclk);

        $display("Sent %0d bases under limits 127, 5, 1, 0, 127, %0d; %0d results checked.",
                 bases_sent, seg_limit[5], tally.checked);
        $display("%0d full windows, %0d counts held at the limit.",
                 tally.full_windows, tally.held);
        if (tally.failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Table clear alone writes 2^24 entries; allow plenty on top.
    initial begin
        #700_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

FILE: canonical_kmer_counter.f
+incdir+design
design/ckc_pkg.sv
design/ckc_ctrl.sv
design/ckc_datapath.sv
design/canonical_kmer_counter.sv
design/ckc_checker.sv
sim/canonical_kmer_counter_tb.sv
